>>> rtl/core/wrp_pkg.sv
`timescale 1ns / 1ps

package wrp_pkg;

    // Little-endian four-character codes as they arrive on the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
    localparam logic [31:0] TAG_VP8  = 32'h2038_5056;
    localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;
    localparam logic [31:0] TAG_VP8X = 32'h5838_5056;
    localparam logic [31:0] TAG_ALPH = 32'h4850_4C41;

    localparam logic [31:0] HEADER_MIN = 32'd12;
    localparam logic [31:0] SIZE_BAD   = 32'hFFFF_FFFF;

    // Result kinds
    localparam logic [1:0] KIND_LOSSY    = 2'd0;
    localparam logic [1:0] KIND_LOSSLESS = 2'd1;
    localparam logic [1:0] KIND_ALPHA    = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    // End-of-packet status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_NO_RIFF    = 3'd2;
    localparam logic [2:0] ST_RIFF_SIZE  = 3'd3;
    localparam logic [2:0] ST_NO_WEBP    = 3'd4;
    localparam logic [2:0] ST_CHUNK_SIZE = 3'd5;
    localparam logic [2:0] ST_NO_IMAGE   = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  status;
        logic [24:0] width;
        logic [24:0] height;
        logic [4:0]  flags;
        logic        alpha_acc;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } res_slot_t;

endpackage

>>> rtl/core/wrp_parser.sv
`timescale 1ns / 1ps

module wrp_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output wrp_pkg::res_slot_t slot_byte,
    output wrp_pkg::res_slot_t slot_status
);
    import wrp_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WEBP, PH_CTYPE, PH_CSIZE, PH_SKIP, PH_IMAGE,
        PH_VP8X, PH_AHDR, PH_ADATA, PH_ERR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [3:0]  fs_reg, fs_next;
    logic [31:0] riff_reg, riff_next;
    logic [31:0] ctype_reg, ctype_next;
    logic [31:0] cleft_reg, cleft_next;
    logic        image_reg, image_next;
    logic        dims_reg, dims_next;
    logic [23:0] wf_reg, wf_next;
    logic [23:0] hf_reg, hf_next;
    logic [4:0]  flags_reg, flags_next;
    logic [48:0] aleft_reg, aleft_next;
    logic [2:0]  err_reg, err_next;
    logic        aok_reg, aok_next;
    logic [48:0] area_reg;

    logic [24:0] w_cur, h_cur, w_fin, h_fin;
    logic [31:0] byte_sh, size_w, cleft_dec;
    logic        field_done, in_body, riff_big;
    logic [2:0]  st;

    // Area of the frame, ready long before any ALPH header can follow VP8X
    assign w_cur = dims_reg ? ({1'b0, wf_reg} + 25'd1) : '0;
    assign h_cur = dims_reg ? ({1'b0, hf_reg} + 25'd1) : '0;

    always_ff @(posedge clk)
    begin
        area_reg <= 49'(w_cur * h_cur);
    end

    assign byte_sh    = {24'd0, in_byte} << {fs_reg[1:0], 3'b000};
    assign field_done = (fs_reg[1:0] == 2'd3);
    assign size_w     = cleft_reg | byte_sh;
    assign cleft_dec  = (cleft_reg != '0) ? cleft_reg - 32'd1 : cleft_reg;

    // Advance the parse state by one byte
    always_comb
    begin
        phase_next = phase_reg;
        bpos_next  = (bpos_reg != '1) ? bpos_reg + 32'd1 : bpos_reg;
        fs_next    = fs_reg;
        riff_next  = riff_reg;
        ctype_next = ctype_reg;
        cleft_next = cleft_reg;
        image_next = image_reg;
        dims_next  = dims_reg;
        wf_next    = wf_reg;
        hf_next    = hf_reg;
        flags_next = flags_reg;
        aleft_next = aleft_reg;
        err_next   = err_reg;
        aok_next   = aok_reg;
        slot_byte  = '0;

        unique case (phase_reg)
            PH_RIFF, PH_WEBP, PH_CTYPE:
            begin
                ctype_next = ctype_reg | byte_sh;
                fs_next    = fs_reg + 4'd1;
                if (field_done)
                begin
                    fs_next = '0;
                    if (phase_reg == PH_RIFF)
                    begin
                        if (ctype_next != TAG_RIFF)
                        begin
                            err_next   = ST_NO_RIFF;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = PH_RSIZE;
                        end
                        ctype_next = '0;
                    end
                    else if (phase_reg == PH_WEBP)
                    begin
                        if (ctype_next != TAG_WEBP)
                        begin
                            err_next   = ST_NO_WEBP;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = PH_CTYPE;
                            ctype_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_CSIZE;
                        cleft_next = '0;
                    end
                end
            end
            PH_RSIZE:
            begin
                riff_next = riff_reg | byte_sh;
                fs_next   = fs_reg + 4'd1;
                if (field_done)
                begin
                    fs_next    = '0;
                    phase_next = PH_WEBP;
                    ctype_next = '0;
                end
            end
            PH_CSIZE:
            begin
                cleft_next = size_w;
                fs_next    = fs_reg + 4'd1;
                if (field_done)
                begin
                    if (size_w == SIZE_BAD || (size_w >> SIZE_BITS) != '0)
                    begin
                        err_next   = ST_CHUNK_SIZE;
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        // Round an odd size up to the pad byte
                        cleft_next = size_w + {31'd0, size_w[0]};
                        fs_next    = '0;
                        if (ctype_reg == TAG_VP8 || ctype_reg == TAG_VP8L)
                        begin
                            phase_next = image_reg ? PH_SKIP : PH_IMAGE;
                            image_next = 1'b1;
                        end
                        else if (ctype_reg == TAG_VP8X)
                        begin
                            dims_next  = 1'b1;
                            wf_next    = '0;
                            hf_next    = '0;
                            flags_next = '0;
                            phase_next = PH_VP8X;
                        end
                        else if (ctype_reg == TAG_ALPH)
                        begin
                            phase_next = PH_AHDR;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                        if (cleft_next == '0)
                        begin
                            phase_next = PH_CTYPE;
                            ctype_next = '0;
                        end
                    end
                end
            end
            PH_SKIP, PH_IMAGE, PH_VP8X, PH_AHDR, PH_ADATA:
            begin
                cleft_next = cleft_dec;
                if (phase_reg == PH_IMAGE)
                begin
                    slot_byte.valid    = 1'b1;
                    slot_byte.res.kind = (ctype_reg == TAG_VP8) ? KIND_LOSSY : KIND_LOSSLESS;
                    slot_byte.res.data = in_byte;
                end
                else if (phase_reg == PH_VP8X)
                begin
                    unique case (fs_reg)
                        4'd0:    flags_next      = in_byte[5:1];
                        4'd4:    wf_next[7:0]    = wf_reg[7:0] | in_byte;
                        4'd5:    wf_next[15:8]   = wf_reg[15:8] | in_byte;
                        4'd6:    wf_next[23:16]  = wf_reg[23:16] | in_byte;
                        4'd7:    hf_next[7:0]    = hf_reg[7:0] | in_byte;
                        4'd8:    hf_next[15:8]   = hf_reg[15:8] | in_byte;
                        4'd9:    hf_next[23:16]  = hf_reg[23:16] | in_byte;
                        default: ;
                    endcase
                    if (fs_reg < 4'd10)
                    begin
                        fs_next = fs_reg + 4'd1;
                    end
                end
                else if (phase_reg == PH_AHDR)
                begin
                    // Accept only raw, unfiltered, unprocessed alpha
                    if (in_byte[5:0] == 6'd0)
                    begin
                        aok_next   = 1'b1;
                        aleft_next = area_reg;
                        phase_next = PH_ADATA;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else if (phase_reg == PH_ADATA)
                begin
                    if (aleft_reg != '0)
                    begin
                        aleft_next         = aleft_reg - 49'd1;
                        slot_byte.valid    = 1'b1;
                        slot_byte.res.kind = KIND_ALPHA;
                        slot_byte.res.data = in_byte;
                    end
                end
                if (cleft_dec == '0)
                begin
                    phase_next = PH_CTYPE;
                    fs_next    = '0;
                    ctype_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Build the end-of-packet status from the updated state
    assign w_fin    = dims_next ? ({1'b0, wf_next} + 25'd1) : '0;
    assign h_fin    = dims_next ? ({1'b0, hf_next} + 25'd1) : '0;
    assign in_body  = (phase_next == PH_SKIP || phase_next == PH_IMAGE ||
                       phase_next == PH_VP8X || phase_next == PH_AHDR ||
                       phase_next == PH_ADATA) && (cleft_next != '0);
    assign riff_big = (riff_next >> SIZE_BITS) != '0;

    always_comb
    begin
        priority if (bpos_next < HEADER_MIN)
            st = ST_SHORT;
        else if (err_next == ST_NO_RIFF)
            st = ST_NO_RIFF;
        else if (riff_big || (bpos_next - 32'd8) < riff_next)
            st = ST_RIFF_SIZE;
        else if (err_next != ST_OK)
            st = err_next;
        else if (in_body)
            st = ST_CHUNK_SIZE;
        else if (!image_next)
            st = ST_NO_IMAGE;
        else
            st = ST_OK;
    end

    always_comb
    begin
        slot_status               = '0;
        slot_status.valid         = step && in_last;
        slot_status.res.kind      = KIND_STATUS;
        slot_status.res.status    = st;
        slot_status.res.width     = w_fin;
        slot_status.res.height    = h_fin;
        slot_status.res.flags     = flags_next;
        slot_status.res.alpha_acc = aok_next;
        slot_status.res.last      = 1'b1;
    end

    // Hold state; drop back to the packet start after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            bpos_reg  <= '0;
            fs_reg    <= '0;
            riff_reg  <= '0;
            ctype_reg <= '0;
            cleft_reg <= '0;
            image_reg <= 1'b0;
            dims_reg  <= 1'b0;
            wf_reg    <= '0;
            hf_reg    <= '0;
            flags_reg <= '0;
            aleft_reg <= '0;
            err_reg   <= '0;
            aok_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (in_last)
            begin
                phase_reg <= PH_RIFF;
                bpos_reg  <= '0;
                fs_reg    <= '0;
                riff_reg  <= '0;
                ctype_reg <= '0;
                cleft_reg <= '0;
                image_reg <= 1'b0;
                dims_reg  <= 1'b0;
                wf_reg    <= '0;
                hf_reg    <= '0;
                flags_reg <= '0;
                aleft_reg <= '0;
                err_reg   <= '0;
                aok_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                bpos_reg  <= bpos_next;
                fs_reg    <= fs_next;
                riff_reg  <= riff_next;
                ctype_reg <= ctype_next;
                cleft_reg <= cleft_next;
                image_reg <= image_next;
                dims_reg  <= dims_next;
                wf_reg    <= wf_next;
                hf_reg    <= hf_next;
                flags_reg <= flags_next;
                aleft_reg <= aleft_next;
                err_reg   <= err_next;
                aok_reg   <= aok_next;
            end
        end
    end

    a_packet_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_last) |=> (phase_reg == PH_RIFF && bpos_reg == '0))
        else $error("parser did not restart after packet end");

    a_alpha_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ADATA) |-> aok_reg)
        else $error("alpha data phase without accepted alpha header");

endmodule

>>> rtl/core/wrp_out_fifo.sv
`timescale 1ns / 1ps

module wrp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  wrp_pkg::res_slot_t slot_a,
    input  wrp_pkg::res_slot_t slot_b,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output wrp_pkg::result_t   out_res
);
    import wrp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     count_reg, count_next;
    logic [PW:0]     push_cnt;
    logic            pop;
    logic [PW-1:0]   wp_b;

    assign push_cnt  = (PW+1)'(slot_a.valid) + (PW+1)'(slot_b.valid);
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rp_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= (PW+1)'(DEPTH - 2));
    assign wp_b      = slot_a.valid ? wp_reg + PW'(1) : wp_reg;
    assign count_next = count_reg + push_cnt - (PW+1)'(pop);

    // Store up to two results per cycle, in order
    always_ff @(posedge clk)
    begin
        if (slot_a.valid)
        begin
            mem[wp_reg] <= slot_a.res;
        end
        if (slot_b.valid)
        begin
            mem[wp_b] <= slot_b.res;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + push_cnt[PW-1:0];
            rp_reg    <= rp_reg + PW'(pop);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != '0) |-> ((count_reg + push_cnt) <= (PW+1)'(DEPTH)))
        else $error("result queue overflow");

endmodule

>>> rtl/core/webp_riff_chunk_parser_core.sv
`timescale 1ns / 1ps

// Streaming WebP container parser. Takes one file byte per cycle with in_last
// on the packet's final byte, and returns the padded payload of the first
// VP8/VP8L chunk, the raw alpha bytes of an uncompressed ALPH chunk (capped at
// width*height from VP8X) and one end status with dimensions and feature flags.
// Each accepted byte is registered in the input register, parsed once the
// result queue has room and written into that queue, whose head drives the
// output. Sustained rate is one byte per cycle while the input is not
// stalled; a final byte that also forwards a payload byte yields two
// results, which the four-entry result queue drains at one per cycle, so
// input stalls only when the output side stalls or such pairs arrive densely.
// No clearing pass after reset: the block accepts bytes from the first cycle.
module webp_riff_chunk_parser_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic [24:0] image_width,
    output logic [24:0] image_height,
    output logic [4:0]  feature_flags,
    output logic        alpha_accepted,
    output logic        out_last
);
    import wrp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       room;
    logic       advance;
    logic       accept;
    res_slot_t  slot_byte, slot_status;
    res_slot_t  slot_a, slot_b;
    result_t    out_res;

    assign advance  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    // Capture each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    wrp_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (in_byte_reg),
        .in_last     (in_last_reg),
        .slot_byte   (slot_byte),
        .slot_status (slot_status)
    );

    // Gate parser results with the step that produced them
    always_comb
    begin
        slot_a       = slot_byte;
        slot_a.valid = slot_byte.valid && advance;
        slot_b       = slot_status;
        slot_b.valid = slot_status.valid && advance;
    end

    wrp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot_a    (slot_a),
        .slot_b    (slot_b),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_kind       = out_res.kind;
    assign out_byte       = out_res.data;
    assign status         = out_res.status;
    assign image_width    = out_res.width;
    assign image_height   = out_res.height;
    assign feature_flags  = out_res.flags;
    assign alpha_accepted = out_res.alpha_acc;
    assign out_last       = out_res.last;

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (out_kind == KIND_STATUS))
        else $error("packet end flag on a byte result");

    a_byte_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != KIND_STATUS) |->
            (status == ST_OK && image_width == '0 && !out_last))
        else $error("byte result carries status fields");

endmodule
